[rtl/dtc_pkg.sv]
`default_nettype none
package dtc_pkg;
  localparam int CODE_W  = 12;
  localparam int CNT_W   = 21;
  localparam int TIME_W  = 24;
  localparam int CURR_W  = 13;
  localparam int ENTRY_W = TIME_W + CODE_W + CURR_W;
  localparam int LOG_DEPTH = 128;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_CUTOFF = 3'd1;
  localparam logic [2:0] REG_DMAX   = 3'd2;
  localparam logic [2:0] REG_DSTART = 3'd3;
  localparam logic [2:0] REG_HOLD   = 3'd4;
  localparam logic [2:0] REG_LOWLIM = 3'd5;
  localparam logic [2:0] REG_SLIMIT = 3'd6;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [CODE_W-1:0] v;
    logic signed [CURR_W-1:0] c;
  } entry_t;

  // multiplier control between sequencer and shared unit
  typedef struct packed {
    logic               load;
    logic signed [33:0] a;
    logic signed [33:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

[rtl/discharge_test_controller_top.sv]
`default_nettype none
// channel | valid    | stall    | payload
// in      | in_valid | in_stall | req_type .. read_index
// out     | out_valid| out_stall| drive_level .. log_curr
// cfg     | cfg_we   | -        | cfg_index, cfg_data
// a read request passes S_RD and S_RDW (log memory read), then S_OUT; a sample passes
// S_M1 and S_M2 (two products in the shared multiplier), S_ACC, S_LOG and S_OUT;
// a sample after the test is done goes from acceptance straight to S_OUT.
// when the log fills, a halving pass walks LOG_DEPTH/2 pairs, each through S_HRA, S_HRB
// and S_HWR, between S_ACC and S_LOG.
// in_stall is high from acceptance until the result is taken at the output, and the
// next request can be taken in the following cycle.
// reset is synchronous; the log memory is not cleared.
module discharge_test_controller_top
  import dtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [19:0] cfg_data,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic req_type,
  input  wire logic [11:0] batt_code,
  input  wire logic [11:0] shunt_hi_code,
  input  wire logic [11:0] shunt_lo_code,
  input  wire logic [20:0] elapsed_us,
  input  wire logic [23:0] time_s,
  input  wire logic [6:0] read_index,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [11:0] drive_level,
  output logic      done_res,
  output logic      low_detected,
  output logic signed [55:0] charge_sum,
  output logic signed [63:0] energy_sum,
  output logic [6:0] entry_count,
  output logic [23:0] log_time,
  output logic [11:0] log_volt,
  output logic signed [12:0] log_curr
);
  localparam int AW = $clog2(LOG_DEPTH);
  localparam int HALF = LOG_DEPTH / 2;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_M1 = 4'd3,
                         S_M2 = 4'd4, S_ACC = 4'd5, S_HRA = 4'd6, S_HRB = 4'd7,
                         S_HWR = 4'd8, S_LOG = 4'd9, S_OUT = 4'd10, S_FIN = 4'd11;

  logic [3:0] state;
  // configuration registers
  logic [11:0] current_target, cutoff_code, drive_max, drive_start, hold_level;
  logic [2:0]  low_limit;
  logic [19:0] sample_limit;
  // controller state
  logic [11:0] drive_acc;
  logic [2:0]  low_count;
  logic [CNT_W-1:0] sample_count, stop_count;
  logic [3:0]  decim_shift;
  logic [39:0] time_acc;
  logic [27:0] volt_acc;
  logic signed [28:0] curr_acc;
  logic signed [55:0] charge_acc;
  logic signed [63:0] energy_acc;
  // captured request
  logic        r_type;
  logic [11:0] r_batt;
  logic signed [12:0] r_diff;
  logic [20:0] r_us;
  logic [23:0] r_ts;
  logic [AW-1:0] r_idx;
  logic signed [55:0] pcharge;
  logic [AW-1:0] hcnt;
  entry_t ent_a;

  // log memory
  entry_t mem [LOG_DEPTH];
  entry_t rdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  entry_t wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  mul_req_t mreq;
  logic signed [67:0] prod;
  dtc_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  logic done_now;
  assign done_now = sample_count >= stop_count;
  assign in_stall = (state != S_IDLE);

  // drive update (combinational, narrow)
  logic signed [14:0] err;
  logic signed [14:0] drv;
  logic [2:0] lc_next;
  always_comb begin
    err = $signed({3'b0, current_target}) - 15'(r_diff);
    drv = $signed({3'b0, drive_acc}) + err / 15'sd8;
    if (drv < 0) drv = '0;
    if (drv > $signed({3'b0, drive_max})) drv = $signed({3'b0, drive_max});
    lc_next = low_count;
    if (r_batt < cutoff_code && low_count != 3'd7) lc_next = low_count + 3'd1;
    if (lc_next > low_limit) drv = $signed({3'b0, hold_level});
  end

  // saturating sums
  logic signed [56:0] ch_sum;
  logic signed [64:0] en_sum;
  assign ch_sum = 57'(charge_acc) + 57'(pcharge);
  assign en_sum = 65'(energy_acc) + 65'(prod);

  // block / halving arithmetic
  logic [CNT_W-1:0] mask;
  logic [CNT_W-1:0] cshift;
  logic [39:0] tsum;
  logic [27:0] vsum;
  logic signed [28:0] csum;
  logic [24:0] ht;
  logic [12:0] hv;
  logic signed [13:0] hc;
  logic [44:0] tenth_prod;
  logic [CNT_W+3:0] stop_ext;
  always_comb begin
    mask = CNT_W'((22'd1 << decim_shift) - 22'd1);
    cshift = sample_count >> decim_shift;
    tsum = time_acc + 40'(r_ts);
    vsum = volt_acc + 28'(r_batt);
    csum = curr_acc + 29'(r_diff);
    ht = 25'(ent_a.t) + 25'(rdata.t);
    hv = 13'(ent_a.v) + 13'(rdata.v);
    hc = 14'(ent_a.c) + 14'(rdata.c);
    // count/10 by reciprocal multiply, exact for counts below 2^22
    tenth_prod = 45'(sample_count) * 45'(21'd1677722);
    stop_ext = (CNT_W+4)'(sample_count) + (CNT_W+4)'(tenth_prod[44:24]);
  end

  always_comb begin
    mreq.load = (state == S_M1) || (state == S_M2);
    mreq.a = (state == S_M1) ? 34'(signed'({1'b0, r_us})) : $signed(prod[33:0]);
    mreq.b = (state == S_M1) ? 34'(r_diff) : 34'(signed'({1'b0, r_batt}));
    raddr = r_idx;
    if (state == S_HRA) raddr = {hcnt[AW-2:0], 1'b0};
    if (state == S_HRB) raddr = {hcnt[AW-2:0], 1'b1};
    we = 1'b0;
    waddr = hcnt;
    wdata.t = ht[24:1];
    wdata.v = hv[12:1];
    wdata.c = hc[13:1];
    if (state == S_HWR) we = 1'b1;
    if (state == S_LOG && ((sample_count & mask) == mask)) begin
      we = 1'b1;
      waddr = cshift[AW-1:0];
      wdata.t = 24'(tsum >> decim_shift);
      wdata.v = 12'(vsum >> decim_shift);
      wdata.c = 13'(csum >>> decim_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      current_target <= 12'd627; cutoff_code <= 12'd592; drive_max <= 12'd1024;
      drive_start <= 12'd614; hold_level <= 12'd204; low_limit <= 3'd5;
      sample_limit <= 20'd1000000;
      drive_acc <= 12'd614; low_count <= '0; sample_count <= '0;
      stop_count <= CNT_W'(1000000); decim_shift <= '0;
      time_acc <= '0; volt_acc <= '0; curr_acc <= '0;
      charge_acc <= '0; energy_acc <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: current_target <= cfg_data[11:0];
          REG_CUTOFF: cutoff_code <= cfg_data[11:0];
          REG_DMAX:   drive_max <= cfg_data[11:0];
          REG_DSTART: begin
            drive_start <= cfg_data[11:0];
            if (sample_count == '0) drive_acc <= cfg_data[11:0];
          end
          REG_HOLD:   hold_level <= cfg_data[11:0];
          REG_LOWLIM: low_limit <= cfg_data[2:0];
          REG_SLIMIT: begin
            sample_limit <= cfg_data;
            if (sample_count == '0) stop_count <= CNT_W'(cfg_data);
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          r_type <= req_type; r_batt <= batt_code;
          r_diff <= $signed({1'b0, shunt_hi_code}) - $signed({1'b0, shunt_lo_code});
          r_us <= elapsed_us; r_ts <= time_s; r_idx <= AW'(read_index);
          if (req_type) state <= S_RD;
          else if (done_now) state <= S_OUT;
          else state <= S_M1;
        end
        S_RD:  state <= S_RDW;
        S_RDW: state <= S_OUT;
        S_M1:  state <= S_M2;
        S_M2: begin
          pcharge <= 56'(prod);
          state <= S_ACC;
        end
        S_ACC: begin
          // product of charge term and battery code is in prod now
          if (ch_sum > 57'sh0_7FFFFF_FFFFFFFF) charge_acc <= {1'b0, {55{1'b1}}};
          else if (ch_sum < -57'sh0_80000000000000) charge_acc <= {1'b1, 55'd0};
          else charge_acc <= 56'(ch_sum);
          if (en_sum[64] != en_sum[63]) energy_acc <= {en_sum[64], {63{~en_sum[64]}}};
          else energy_acc <= 64'(en_sum);
          low_count <= lc_next;
          if (lc_next == low_limit)
            stop_count <= (stop_ext > (CNT_W+4)'({CNT_W{1'b1}})) ? {CNT_W{1'b1}}
                                                                 : CNT_W'(stop_ext);
          drive_acc <= 12'(drv);
          hcnt <= '0;
          if (cshift == CNT_W'(LOG_DEPTH) && decim_shift != 4'd15) begin
            decim_shift <= decim_shift + 4'd1;
            state <= S_HRA;
          end else state <= S_LOG;
        end
        S_HRA: state <= S_HRB;
        S_HRB: begin
          ent_a <= rdata;
          state <= S_HWR;
        end
        S_HWR: begin
          hcnt <= hcnt + 1'b1;
          state <= (hcnt == AW'(HALF - 1)) ? S_LOG : S_HRA;
        end
        S_LOG: begin
          if ((sample_count & mask) == mask) begin
            time_acc <= '0; volt_acc <= '0; curr_acc <= '0;
          end else begin
            time_acc <= tsum; volt_acc <= vsum; curr_acc <= csum;
          end
          sample_count <= sample_count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_FIN;
        end
        S_FIN: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loaded in S_OUT
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      drive_level <= done_now ? 12'd0 : drive_acc;
      done_res <= done_now;
      low_detected <= low_count >= low_limit;
      charge_sum <= charge_acc;
      energy_sum <= energy_acc;
      entry_count <= (cshift > CNT_W'(LOG_DEPTH - 1)) ? 7'(LOG_DEPTH - 1) : 7'(cshift);
      log_time <= r_type ? rdata.t : '0;
      log_volt <= r_type ? rdata.v : '0;
      log_curr <= r_type ? rdata.c : '0;
    end
  end
endmodule
`default_nettype wire

[rtl/dtc_mul.sv]
`default_nettype none
module dtc_mul
  import dtc_pkg::*;
(
  input  wire logic               clk,
  input  wire mul_req_t           req,
  output logic signed [67:0]      prod
);
  // registered 34x34 multiply shared by the charge and energy steps
  always_ff @(posedge clk) begin
    if (req.load) prod <= req.a * req.b;
  end
endmodule
`default_nettype wire

[rtl/dtc_checker.sv]
`default_nettype none
module dtc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic done_res,
  input wire logic [11:0] drive_level
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("no busy after request");
  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> drive_level == 12'd0) else $error("drive while done");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
bind discharge_test_controller_top dtc_checker u_chk (.*);
`default_nettype wire
